// ===== rtl/pfd_pkg.sv =====
// Shared types and constants for the pose frame deframer.
// No dependencies; used by pfd_frame_fsm and pose_frame_deframer.
package pfd_pkg;

   localparam logic [7:0] HDR_FIRST  = 8'h0D;
   localparam logic [7:0] HDR_SECOND = 8'h0A;
   localparam logic [7:0] TRL_FIRST  = 8'h0A;
   localparam logic [7:0] TRL_SECOND = 8'h0D;

   localparam int unsigned PAYLOAD_LEN = 24;
   localparam int unsigned WORD_COUNT  = 6;
   localparam int unsigned INDEX_W     = 5;

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(PAYLOAD_LEN - 1);

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_HDR2 = 5'b00010,
      PH_DATA = 5'b00100,
      PH_TRL1 = 5'b01000,
      PH_TRL2 = 5'b10000
   } phase_type;

   typedef struct packed {
      logic store_en;    // shift this byte into the payload store
      logic frame_done;  // final trailer byte matched
   } ctrl_type;

endpackage

// ===== rtl/pose_frame_deframer.sv =====
// Pose frame deframer top: payload shift store and result register.
// Depends on pfd_pkg and pfd_frame_fsm.
// Latency: a result is valid the cycle after its final trailer byte is accepted.
// Throughput: one byte per cycle; req_ready drops only while a result waits on rsp_ready.
// Reset: synchronous, active high; clears frame state and result valid, store is not cleared.
module pose_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_heading_bits,
   output logic [31:0] rsp_tilt_x_bits,
   output logic [31:0] rsp_tilt_y_bits,
   output logic [31:0] rsp_position_x_bits,
   output logic [31:0] rsp_position_y_bits,
   output logic [31:0] rsp_turn_rate_bits
);

   pfd_pkg::ctrl_type ctrl;
   logic              step;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        store_ff [pfd_pkg::PAYLOAD_LEN];
   logic [31:0]       word     [pfd_pkg::WORD_COUNT];
   logic [31:0]       word_ff  [pfd_pkg::WORD_COUNT];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   pfd_frame_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (req_rx_byte),
      .ctrl    (ctrl)
   );

   // Bytes shift in at the top; after a full payload slot 0 holds the first byte.
   always_ff @(posedge clock) begin
      if (ctrl.store_en) begin
         for (int i = 0; i < pfd_pkg::PAYLOAD_LEN - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[pfd_pkg::PAYLOAD_LEN-1] <= req_rx_byte;
      end
   end

   always_comb begin
      for (int k = 0; k < pfd_pkg::WORD_COUNT; k++) begin
         word[k] = {store_ff[4*k+3], store_ff[4*k+2], store_ff[4*k+1], store_ff[4*k]};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.frame_done) begin
         word_ff <= word;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_heading_bits    = word_ff[0];
   assign rsp_tilt_x_bits     = word_ff[1];
   assign rsp_tilt_y_bits     = word_ff[2];
   assign rsp_position_x_bits = word_ff[3];
   assign rsp_position_y_bits = word_ff[4];
   assign rsp_turn_rate_bits  = word_ff[5];

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_done |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before transaction completed");

   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_done |=> rsp_valid_ff)
      else $error("completed frame did not raise rsp_valid");

   a_store_needs_step: assert property (@(posedge clock) disable iff (reset)
      ctrl.store_en || ctrl.frame_done |-> step)
      else $error("store or result without an accepted byte");

endmodule

// ===== rtl/pfd_frame_fsm.sv =====
// Frame sync state machine: header hunt, payload count, trailer check.
// Depends on pfd_pkg.
module pfd_frame_fsm (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   output pfd_pkg::ctrl_type  ctrl
);

   pfd_pkg::phase_type               phase_ff, phase_in;
   logic [pfd_pkg::INDEX_W-1:0]      byte_index_ff, byte_index_in;

   always_comb begin
      phase_in        = phase_ff;
      byte_index_in   = byte_index_ff;
      ctrl.store_en   = 1'b0;
      ctrl.frame_done = 1'b0;
      if (step) begin
         unique case (phase_ff)
            pfd_pkg::PH_HUNT: begin
               phase_in = (rx_byte == pfd_pkg::HDR_FIRST) ? pfd_pkg::PH_HDR2
                                                         : pfd_pkg::PH_HUNT;
            end
            pfd_pkg::PH_HDR2: begin
               if (rx_byte == pfd_pkg::HDR_SECOND) begin
                  byte_index_in = '0;
                  phase_in      = pfd_pkg::PH_DATA;
               end else if (rx_byte != pfd_pkg::HDR_FIRST) begin
                  phase_in = pfd_pkg::PH_HUNT;
               end
            end
            pfd_pkg::PH_DATA: begin
               ctrl.store_en = 1'b1;
               if (byte_index_ff == pfd_pkg::LAST_INDEX) begin
                  byte_index_in = '0;
                  phase_in      = pfd_pkg::PH_TRL1;
               end else begin
                  byte_index_in = byte_index_ff + 1'b1;
               end
            end
            pfd_pkg::PH_TRL1: begin
               phase_in = (rx_byte == pfd_pkg::TRL_FIRST) ? pfd_pkg::PH_TRL2
                                                         : pfd_pkg::PH_HUNT;
            end
            pfd_pkg::PH_TRL2: begin
               ctrl.frame_done = (rx_byte == pfd_pkg::TRL_SECOND);
               phase_in        = pfd_pkg::PH_HUNT;
            end
            default: begin
               phase_in = pfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pfd_pkg::PH_HUNT;
         byte_index_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
      end
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= pfd_pkg::LAST_INDEX)
      else $error("payload index out of range");

   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   a_trl2_to_hunt: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == pfd_pkg::PH_TRL2 |=> phase_ff == pfd_pkg::PH_HUNT)
      else $error("no return to hunt after last trailer byte");

   a_hdr_starts_data: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == pfd_pkg::PH_HDR2 && rx_byte == pfd_pkg::HDR_SECOND
      |=> phase_ff == pfd_pkg::PH_DATA && byte_index_ff == '0)
      else $error("payload collection did not start at slot zero");

endmodule
